// ===== design/mava_pkg.sv =====
// ----------------------------------------------------------------------------
// mava_pkg: shared widths and helpers for the mesh area/volume/box accumulator
// Holds the widths and the saturating arithmetic used by the lane and merge
// modules.
// ----------------------------------------------------------------------------
`default_nettype none
package mava_pkg;
	localparam int COORD_BITS_DEF = 20;
	localparam int ACC_W          = 64;
	localparam int SUM_W          = 63;
	localparam logic [ACC_W-1:0] MAX63 = {1'b0, {SUM_W{1'b1}}};

	// Saturating unsigned add, result capped at 2^63-1.
	function automatic logic [ACC_W-1:0] sat_add63(input logic [ACC_W-1:0] s,
			input logic [ACC_W-1:0] t);
		logic [ACC_W-1:0] sc;
		logic [ACC_W:0]   sum;
		sc  = (s > MAX63) ? MAX63 : s;
		sum = {1'b0, sc} + {1'b0, t};
		sat_add63 = (sum > {1'b0, MAX63}) ? MAX63 : sum[ACC_W-1:0];
	endfunction

	// Saturating signed add, result held within +-(2^63-1).
	function automatic logic signed [ACC_W-1:0] sat_adds(input logic signed [ACC_W-1:0] s,
			input logic signed [ACC_W-1:0] t);
		logic signed [ACC_W:0] sum;
		sum = {s[ACC_W-1], s} + {t[ACC_W-1], t};
		if (sum > $signed({2'b00, MAX63[SUM_W-1:0]}))
			sat_adds = $signed(MAX63);
		else if (sum < -$signed({2'b00, MAX63[SUM_W-1:0]}))
			sat_adds = -$signed(MAX63);
		else
			sat_adds = sum[ACC_W-1:0];
	endfunction
endpackage
`default_nettype wire

// ===== design/mava_sqrt.sv =====
// ----------------------------------------------------------------------------
// mava_sqrt: rounded integer square root
// Restoring digit-by-digit root of a 128-bit radicand, one result bit per cycle,
// then rounding to nearest.
// ----------------------------------------------------------------------------
`default_nettype none
module mava_sqrt (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [127:0] radicand,
	output logic              done,
	output logic [63:0]       root
);
	logic [127:0] rad_q;
	logic [129:0] rem_q;
	logic [63:0]  r_q;
	logic [6:0]   cnt_q;
	logic         busy_q;
	logic [129:0] trial;
	logic [129:0] rem_sh;

	assign rem_sh = {rem_q[127:0], rad_q[127:126]};
	assign trial  = rem_sh - {64'd0, r_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd64) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q <= radicand;
			rem_q <= '0;
			r_q   <= '0;
		end else if (busy_q) begin
			if (cnt_q != 7'd64) begin
				rad_q <= {rad_q[125:0], 2'b00};
				if (!trial[129]) begin
					rem_q <= trial;
					r_q   <= {r_q[62:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					r_q   <= {r_q[62:0], 1'b0};
				end
			end else begin
				// remainder above root means the root is nearer the next integer
				if (rem_q > {66'd0, r_q} && r_q != '1)
					root <= r_q + 64'd1;
				else
					root <= r_q;
			end
		end
	end
endmodule
`default_nettype wire

// ===== design/mava_lane.sv =====
// ----------------------------------------------------------------------------
// mava_lane: one axis lane
// For one axis it forms the cross component n_i, its square and the volume
// term a_i * (b x c)_i over four strobed steps: products, differences,
// 32-bit partial products and the final sums.
// ----------------------------------------------------------------------------
`default_nettype none
module mava_lane #(
	parameter int COORD_BITS = mava_pkg::COORD_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          step1,
	input  wire logic                          step2,
	input  wire logic                          step3,
	input  wire logic                          step4,
	// coordinates of the two other axes (p = next axis, q = axis after)
	input  wire logic signed [COORD_BITS-1:0]  a_i,
	input  wire logic signed [COORD_BITS-1:0]  a_p,
	input  wire logic signed [COORD_BITS-1:0]  a_q,
	input  wire logic signed [COORD_BITS-1:0]  b_p,
	input  wire logic signed [COORD_BITS-1:0]  b_q,
	input  wire logic signed [COORD_BITS-1:0]  c_p,
	input  wire logic signed [COORD_BITS-1:0]  c_q,
	output logic [63:0]                        n_mag,
	output logic [127:0]                       n_sq,
	output logic [63:0]                        vol_term
);
	localparam int E_W = COORD_BITS + 1;

	logic signed [E_W-1:0]          e1p, e1q, e2p, e2q;
	logic signed [2*E_W-1:0]        pe_a, pe_b;
	logic signed [2*COORD_BITS-1:0] pbc_a, pbc_b;
	logic [63:0] ai;
	logic [63:0] m1_s1, m2_s1, m3_s1, m4_s1;
	logic [63:0] n_s2;
	logic [63:0] bc_s2;
	logic [63:0] hh_s3, hl_s3, ll_s3, vll_s3;
	logic [31:0] vlh_s3, vhl_s3;

	assign e1p   = E_W'(b_p) - E_W'(a_p);
	assign e1q   = E_W'(b_q) - E_W'(a_q);
	assign e2p   = E_W'(c_p) - E_W'(a_p);
	assign e2q   = E_W'(c_q) - E_W'(a_q);
	assign pe_a  = (2*E_W)'(e1p) * (2*E_W)'(e2q);
	assign pe_b  = (2*E_W)'(e1q) * (2*E_W)'(e2p);
	assign pbc_a = (2*COORD_BITS)'(b_p) * (2*COORD_BITS)'(c_q);
	assign pbc_b = (2*COORD_BITS)'(b_q) * (2*COORD_BITS)'(c_p);
	assign ai    = 64'(a_i);

	assign n_mag = n_s2[63] ? (64'd0 - n_s2) : n_s2;

	always_ff @(posedge clk) begin
		if (step1) begin
			m1_s1 <= 64'(pe_a);
			m2_s1 <= 64'(pe_b);
			m3_s1 <= 64'(pbc_a);
			m4_s1 <= 64'(pbc_b);
		end
		if (step2) begin
			n_s2  <= m1_s1 - m2_s1;
			bc_s2 <= m3_s1 - m4_s1;
		end
		// split the 64-bit products into 32-bit halves
		if (step3) begin
			hh_s3  <= {32'd0, n_mag[63:32]} * {32'd0, n_mag[63:32]};
			hl_s3  <= {32'd0, n_mag[63:32]} * {32'd0, n_mag[31:0]};
			ll_s3  <= {32'd0, n_mag[31:0]} * {32'd0, n_mag[31:0]};
			vll_s3 <= {32'd0, ai[31:0]} * {32'd0, bc_s2[31:0]};
			vlh_s3 <= ai[31:0] * bc_s2[63:32];
			vhl_s3 <= ai[63:32] * bc_s2[31:0];
		end
		if (step4) begin
			n_sq     <= {hh_s3, ll_s3} + {31'd0, hl_s3, 33'd0};
			vol_term <= vll_s3 + {vlh_s3 + vhl_s3, 32'd0};
		end
	end
endmodule
`default_nettype wire

// ===== design/mava_merge.sv =====
// ----------------------------------------------------------------------------
// mava_merge: merge of lane results into the running sums
// Sums the lane outputs, accumulates with saturation, and tracks the box.
// ----------------------------------------------------------------------------
`default_nettype none
module mava_merge #(
	parameter int COORD_BITS = mava_pkg::COORD_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            add_en,
	input  wire logic                            clr,
	input  wire logic [2:0][63:0]                n_mag,
	input  wire logic [63:0]                     vol_sum3,
	input  wire logic [63:0]                     root,
	input  wire logic [2:0][2:0][COORD_BITS-1:0] verts,
	output logic [63:0]                          area_q,
	output logic signed [63:0]                   vol_q,
	output logic [2:0][63:0]                     proj_q,
	output logic [2:0][COORD_BITS-1:0]           low_q,
	output logic [2:0][COORD_BITS-1:0]           high_q,
	output logic                                 seen_q
);
	logic [2:0][COORD_BITS-1:0] lo_n, hi_n;

	always_comb begin
		lo_n = low_q;
		hi_n = high_q;
		for (int k = 0; k < 3; k++) begin
			for (int i = 0; i < 3; i++) begin
				if ((!seen_q && k == 0) || $signed(verts[k][i]) < $signed(lo_n[i]))
					lo_n[i] = verts[k][i];
				if ((!seen_q && k == 0) || $signed(verts[k][i]) > $signed(hi_n[i]))
					hi_n[i] = verts[k][i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			area_q <= '0;
			vol_q  <= '0;
			proj_q <= '0;
			low_q  <= '0;
			high_q <= '0;
			seen_q <= 1'b0;
		end else if (clr) begin
			area_q <= '0;
			vol_q  <= '0;
			proj_q <= '0;
			low_q  <= '0;
			high_q <= '0;
			seen_q <= 1'b0;
		end else if (add_en) begin
			area_q <= mava_pkg::sat_add63(area_q, root);
			vol_q  <= mava_pkg::sat_adds(vol_q, vol_sum3);
			for (int i = 0; i < 3; i++)
				proj_q[i] <= mava_pkg::sat_add63(proj_q[i], n_mag[i]);
			low_q  <= lo_n;
			high_q <= hi_n;
			seen_q <= 1'b1;
		end
	end
endmodule
`default_nettype wire

// ===== design/mesh_area_volume_box_accumulator.sv =====
// ----------------------------------------------------------------------------
// mesh_area_volume_box_accumulator: triangle mesh area, volume and box
// Accumulates twice the area, signed volume, axis projections and the
// bounding box over a mesh; emits totals on the last triangle.
// ----------------------------------------------------------------------------
// channel   | dir | handshake              | content
// s_axis    | in  | s_axis_tvalid/tready   | one triangle, tlast = last_triangle
// m_axis    | out | m_axis_tvalid/tready   | mesh totals
// cfg       | in  | cfg_valid/cfg_ready    | solid_flag
//
// The input is not ready again until a triangle has been taken, passed
// through the axis lanes (products, differences, partial squares, sums),
// used to start the root and finished in the bit-serial root.
// A last triangle then adds the divide by six (a load and four 16-bit
// reciprocal steps) and the load of the output register.
// Reset clears all sums and sets solid_flag. A held result stalls the input
// only when the next last triangle is ready to load its totals.
// ----------------------------------------------------------------------------
`default_nettype none
module mesh_area_volume_box_accumulator #(
	parameter int COORD_BITS = mava_pkg::COORD_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	// vertex_a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
	input  wire logic [((9*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
	input  wire logic                   s_axis_tlast,
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	// double_area, enclosed_volume, box_min_x/y/z, box_max_x/y/z,
	// double_proj_x/y/z, box_valid
	output logic [((5*63+6*COORD_BITS+1+7)/8)*8-1:0] m_axis_tdata,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic                   cfg_data
);
	localparam int OUT_W = ((5*63+6*COORD_BITS+1+7)/8)*8;
	localparam int PAY_W = 5*63+6*COORD_BITS+1;
	// ceil(2^19 / 3): exact floor division by three for 18-bit dividends
	localparam logic [17:0] RECIP3   = 18'd174763;
	localparam logic [2:0]  DIV_LAST = 3'd4;

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_MUL  = 9'b000000010,
		ST_SUB  = 9'b000000100,
		ST_PROD = 9'b000001000,
		ST_SUM  = 9'b000010000,
		ST_SQ   = 9'b000100000,
		ST_ROOT = 9'b001000000,
		ST_DIV  = 9'b010000000,
		ST_OUT  = 9'b100000000
	} state_t;

	state_t state_q;
	logic   solid_q, last_q, sq_start, sq_done;
	logic [2:0][2:0][COORD_BITS-1:0] v_q;
	logic [2:0][63:0]  n_mag;
	logic [2:0][127:0] n_sq;
	logic [2:0][63:0]  vt;
	logic [127:0]      rad;
	logic [63:0]       root, vol_sum3;
	logic [63:0]       area_q;
	logic signed [63:0] vol_q;
	logic [2:0][63:0]  proj_q;
	logic [2:0][COORD_BITS-1:0] low_q, high_q;
	logic              seen_q, add_en, clr;
	logic [63:0]       dnum_q, quo_q;
	logic [2:0]        drem_q;
	logic [2:0]        dcnt_q;
	logic [18:0]       dpart;
	logic [34:0]       dprod;
	logic [15:0]       ddigit;
	logic [18:0]       dback;
	logic [63:0]       vmag;
	logic [PAY_W-1:0]  pay, out_q;
	logic              out_valid_q;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign rad           = n_sq[0] + n_sq[1] + n_sq[2];
	assign vol_sum3      = vt[0] + vt[1] + vt[2];
	assign sq_start      = (state_q == ST_SQ);
	assign add_en        = sq_done;
	// load the totals once the output register is free or being drained
	assign clr           = (state_q == ST_OUT) && (!out_valid_q || m_axis_tready);
	assign vmag          = vol_q[63] ? 64'(-vol_q) : 64'(vol_q);

	// one 16-bit digit of the divide by six: halve, then multiply by 1/3
	assign dpart  = {drem_q, dnum_q[63:48]};
	assign dprod  = {17'd0, dpart[18:1]} * {17'd0, RECIP3};
	assign ddigit = dprod[34:19];
	assign dback  = dpart - ({1'b0, ddigit, 2'b00} + {2'b00, ddigit, 1'b0});

	// unpack vertices
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			for (int k = 0; k < 3; k++)
				for (int i = 0; i < 3; i++)
					v_q[k][i] <= s_axis_tdata[(3*k+i)*COORD_BITS +: COORD_BITS];
			last_q <= s_axis_tlast;
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_lane
		mava_lane #(.COORD_BITS(COORD_BITS)) u_lane (
			.clk(clk), .step1(state_q == ST_MUL), .step2(state_q == ST_SUB),
			.step3(state_q == ST_PROD), .step4(state_q == ST_SUM),
			.a_i(v_q[0][i]), .a_p(v_q[0][(i+1)%3]), .a_q(v_q[0][(i+2)%3]),
			.b_p(v_q[1][(i+1)%3]), .b_q(v_q[1][(i+2)%3]),
			.c_p(v_q[2][(i+1)%3]), .c_q(v_q[2][(i+2)%3]),
			.n_mag(n_mag[i]), .n_sq(n_sq[i]), .vol_term(vt[i])
		);
	end

	mava_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start), .radicand(rad),
		.done(sq_done), .root(root)
	);

	mava_merge #(.COORD_BITS(COORD_BITS)) u_merge (
		.clk(clk), .arst_n(arst_n), .add_en(add_en), .clr(clr),
		.n_mag(n_mag), .vol_sum3(vol_sum3), .root(root), .verts(v_q),
		.area_q(area_q), .vol_q(vol_q), .proj_q(proj_q),
		.low_q(low_q), .high_q(high_q), .seen_q(seen_q)
	);

	// control sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			solid_q     <= 1'b1;
			dcnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready)
				solid_q <= cfg_data;
			// hold the result until the consumer takes it
			if (clr)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (s_axis_tvalid) state_q <= ST_MUL;
				ST_MUL:  state_q <= ST_SUB;
				ST_SUB:  state_q <= ST_PROD;
				ST_PROD: state_q <= ST_SUM;
				ST_SUM:  state_q <= ST_SQ;
				ST_SQ:   state_q <= ST_ROOT;
				ST_ROOT: begin
					if (sq_done) begin
						state_q <= last_q ? ST_DIV : ST_IDLE;
						dcnt_q  <= '0;
					end
				end
				ST_DIV: begin
					dcnt_q <= dcnt_q + 3'd1;
					if (dcnt_q == DIV_LAST) state_q <= ST_OUT;
				end
				ST_OUT: if (clr) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// round-half-up divide by six: (|v| + 3) / 6, sixteen quotient bits a cycle
	always_ff @(posedge clk) begin
		if (state_q == ST_DIV) begin
			if (dcnt_q == 3'd0) begin
				dnum_q <= vmag + 64'd3;
				drem_q <= '0;
				quo_q  <= '0;
			end else begin
				dnum_q <= {dnum_q[47:0], 16'd0};
				drem_q <= dback[2:0];
				quo_q  <= {quo_q[47:0], ddigit};
			end
		end
	end

	assign pay = {seen_q, proj_q[2][62:0], proj_q[1][62:0], proj_q[0][62:0],
		high_q[2], high_q[1], high_q[0], low_q[2], low_q[1], low_q[0],
		(solid_q ? quo_q[62:0] : 63'd0), area_q[62:0]};

	// output register: parts the result from the accumulation side
	always_ff @(posedge clk) begin
		if (clr)
			out_q <= pay;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_W'(out_q);

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q)) else $error("state not one-hot");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("held result changed");
	a_clr_after_out: assert property (@(posedge clk) disable iff (!arst_n)
		clr |=> (area_q == 64'd0 && !seen_q)) else $error("sums not cleared");
	a_seen_at_clr: assert property (@(posedge clk) disable iff (!arst_n)
		clr |-> seen_q) else $error("result without box");
endmodule
`default_nettype wire
